// ----- rtl/pssp_pkg.sv -----
package pssp_pkg;

  localparam int MaxVertices = 64;
  localparam int IdxW = $clog2(MaxVertices);
  localparam int CntW = IdxW + 1;
  localparam int CoordW = 16;
  localparam int SumW = CoordW + IdxW;
  localparam int OutW = 24;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_ROT    = 2'd0,
    CFG_SCALE  = 2'd1,
    CFG_OFFX   = 2'd2,
    CFG_OFFY   = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TRIG,
    ST_DSUM,
    ST_SCAN,
    ST_LAST,
    ST_XFORM_A,
    ST_XFORM_B,
    ST_XFORM_C,
    ST_DONE,
    ST_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic trig;
    logic dsum;
    logic scan_start;
    logic scan_step;
    logic xform_a;
    logic xform_b;
    logic xform_c;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;
    logic trig_last;
  } stat_t;

endpackage

// ----- rtl/pssp_ctrl.sv -----
module pssp_ctrl import pssp_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_beat,
  input  op_t   op,
  input  logic  out_taken,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  busy,
  output logic  out_valid
);

  state_t state_r, state_nxt;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:    if (in_beat) state_nxt = (op == OP_QUERY) ? ST_TRIG : ST_OUT;
      ST_TRIG:    if (stat.trig_last) state_nxt = ST_DSUM;
      ST_DSUM:    state_nxt = ST_SCAN;
      ST_SCAN:    if (stat.scan_last) state_nxt = ST_LAST;
      ST_LAST:    state_nxt = ST_XFORM_A;
      ST_XFORM_A: state_nxt = ST_XFORM_B;
      ST_XFORM_B: state_nxt = ST_XFORM_C;
      ST_XFORM_C: state_nxt = ST_DONE;
      ST_DONE:    state_nxt = ST_OUT;
      ST_OUT:     if (out_taken) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  // Command decode.
  always_comb begin
    cmd = '0;
    cmd.load = in_beat;
    unique case (state_r)
      ST_TRIG:    cmd.trig = 1'b1;
      ST_DSUM:    cmd.dsum = 1'b1;
      ST_SCAN:    cmd.scan_step = 1'b1;
      ST_LAST:    cmd.scan_step = 1'b1;
      ST_XFORM_A: cmd.xform_a = 1'b1;
      ST_XFORM_B: cmd.xform_b = 1'b1;
      ST_XFORM_C: cmd.xform_c = 1'b1;
      ST_DONE:    cmd.finish = 1'b1;
      default:    ;
    endcase
    cmd.scan_start = (state_r == ST_DSUM);
  end

  assign busy = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_OUT);

  a_out_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (in_beat && op != OP_QUERY) |=> out_valid) else $error("no result after beat");
  a_idle_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    out_taken |=> !busy) else $error("not idle after result");
  a_no_beat_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_beat) else $error("beat while busy");

endmodule

// ----- rtl/pssp_dp.sv -----
module pssp_dp import pssp_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cmd_t                     cmd,
  output stat_t                    stat,
  input  op_t                      op,
  input  logic signed [CoordW-1:0] vx,
  input  logic signed [CoordW-1:0] vy,
  input  logic [15:0]              dir,
  input  logic [15:0]              rot,
  input  logic [15:0]              scale,
  input  logic signed [OutW-1:0]   offx,
  input  logic signed [OutW-1:0]   offy,
  output logic signed [OutW-1:0]   sx,
  output logic signed [OutW-1:0]   sy,
  output logic                     found,
  output logic [IdxW-1:0]          idx,
  output logic                     full
);

  logic signed [CoordW-1:0] xmem [MaxVertices];
  logic signed [CoordW-1:0] ymem [MaxVertices];
  logic [CntW-1:0] count_r;
  logic signed [SumW-1:0] sumx_r, sumy_r;

  logic [15:0] dir_r;
  logic [1:0] tstep_r;
  logic [3:0][15:0] lane_ang;
  logic [3:0][16:0] lane_z;
  logic [3:0][16:0] lane_p;
  logic [3:0][16:0] lane_mag;
  logic [3:0][15:0] lane_s;
  logic [3:0][1:0] tq_r;
  logic [3:0][16:0] tz_r, tz2_r, tu_r;

  logic signed [15:0] dc_r, ds_r;
  logic signed [40:0] dsum_r;
  logic [CntW-1:0] ptr_r;
  logic signed [CoordW-1:0] rdx_r, rdy_r;
  logic rd_v_r;
  logic [IdxW-1:0] rd_i_r;
  logic signed [48:0] best_r;
  logic [IdxW-1:0] bidx_r;
  logic bfound_r;
  logic signed [CoordW-1:0] px_r, py_r;
  logic signed [15:0] rc_r, rs_r;
  logic signed [33:0] rx_r, ry_r;
  logic signed [51:0] mx_r, my_r;
  logic signed [OutW-1:0] sx_r, sy_r;
  logic full_r;

  // Vertex table writes and running sums.
  always_ff @(posedge clk) begin
    if (cmd.load && op == OP_APPEND && !count_r[IdxW]) begin
      xmem[count_r[IdxW-1:0]] <= vx;
      ymem[count_r[IdxW-1:0]] <= vy;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sumx_r  <= '0;
      sumy_r  <= '0;
    end else if (cmd.load && op == OP_APPEND && !count_r[IdxW]) begin
      count_r <= count_r + 1'b1;
      sumx_r  <= sumx_r + SumW'(vx);
      sumy_r  <= sumy_r + SumW'(vy);
    end else if (cmd.load && op == OP_CLEAR) begin
      count_r <= '0;
      sumx_r  <= '0;
      sumy_r  <= '0;
    end
  end

  // The query angle is held for the whole search.
  always_ff @(posedge clk) begin
    if (cmd.load) dir_r <= dir;
  end

  // Four sine lanes: cos and sin of the direction less the rotation, then of the rotation.
  // Each lane folds its angle into the first quadrant and finishes the
  // polynomial with the quadrant sign.
  always_comb begin
    lane_ang[0] = dir_r - rot + 16'd16384;
    lane_ang[1] = dir_r - rot;
    lane_ang[2] = rot + 16'd16384;
    lane_ang[3] = rot;
    for (int l = 0; l < 4; l++) begin
      lane_z[l] = {2'b0, lane_ang[l][13:0], 1'b0};
      if (lane_ang[l][14]) lane_z[l] = 17'd32768 - lane_z[l];
      lane_p[l] = 17'((34'(tz_r[l]) * 34'(tu_r[l])) >> 15);
      lane_mag[l] = 17'((18'(lane_p[l]) + 18'd1) >> 1);
      if (lane_mag[l] > 17'd16384) lane_mag[l] = 17'd16384;
      lane_s[l] = tq_r[l][1] ? 16'(-lane_mag[l]) : lane_mag[l][15:0];
    end
  end

  // Trig steps: one multiply per lane per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) tstep_r <= '0;
    else if (cmd.trig) tstep_r <= tstep_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.trig) begin
      for (int l = 0; l < 4; l++) begin
        case (tstep_r)
          2'd0: begin
            tq_r[l]  <= lane_ang[l][15:14];
            tz_r[l]  <= lane_z[l];
            tz2_r[l] <= 17'((34'(lane_z[l]) * 34'(lane_z[l])) >> 15);
          end
          2'd1: tu_r[l] <= 17'd21024 - 17'((34'(tz2_r[l]) * 34'd2320) >> 15);
          2'd2: tu_r[l] <= 17'd51472 - 17'((34'(tz2_r[l]) * 34'(tu_r[l])) >> 15);
          default: ;
        endcase
      end
      if (tstep_r == 2'd3) begin
        dc_r <= lane_s[0];
        ds_r <= lane_s[1];
        rc_r <= lane_s[2];
        rs_r <= lane_s[3];
      end
    end
    if (cmd.dsum) dsum_r <= 41'(dc_r * sumx_r) + 41'(ds_r * sumy_r);
  end

  assign stat.trig_last = (tstep_r == 2'd3);

  // Scan: a registered memory read, a registered dot product, then one
  // compare per cycle.
  logic signed [32:0] dot, dot_r;
  logic dot_v_r;
  logic [IdxW-1:0] dot_i_r;
  logic signed [48:0] dval;
  assign dot  = 33'(dc_r * rdx_r) + 33'(ds_r * rdy_r);
  assign dval = 49'($signed({1'b0, count_r}) * dot_r) - 49'(dsum_r);
  assign stat.scan_last = (ptr_r >= count_r);

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      ptr_r    <= '0;
      rd_v_r   <= 1'b0;
      dot_v_r  <= 1'b0;
      best_r   <= '0;
      bidx_r   <= '0;
      bfound_r <= 1'b0;
    end else if (cmd.scan_step) begin
      rd_v_r <= !stat.scan_last;
      if (!stat.scan_last) begin
        rdx_r  <= xmem[ptr_r[IdxW-1:0]];
        rdy_r  <= ymem[ptr_r[IdxW-1:0]];
        rd_i_r <= ptr_r[IdxW-1:0];
        ptr_r  <= ptr_r + 1'b1;
      end
      dot_r   <= dot;
      dot_v_r <= rd_v_r;
      dot_i_r <= rd_i_r;
      if (dot_v_r && dval > best_r) begin
        best_r   <= dval;
        bidx_r   <= dot_i_r;
        bfound_r <= 1'b1;
      end
    end
  end

  // Transform of the chosen vertex over four steps.
  logic signed [49:0] vx_rnd, vy_rnd;
  logic signed [25:0] fx_v, fy_v;
  assign vx_rnd = 50'(mx_r + 52'sd2097152 >>> 22);
  assign vy_rnd = 50'(my_r + 52'sd2097152 >>> 22);
  assign fx_v = 26'(vx_rnd) + 26'(offx);
  assign fy_v = 26'(vy_rnd) + 26'(offy);

  function automatic logic signed [OutW-1:0] sat(input logic signed [25:0] v);
    if (v > 26'sd8388607) return 24'sh7FFFFF;
    if (v < -26'sd8388608) return 24'sh800000;
    return v[OutW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.xform_a) begin
      px_r <= xmem[bidx_r];
      py_r <= ymem[bidx_r];
    end
    if (cmd.xform_b) begin
      rx_r <= 34'(px_r * rc_r) - 34'(py_r * rs_r);
      ry_r <= 34'(px_r * rs_r) + 34'(py_r * rc_r);
    end
    if (cmd.xform_c) begin
      mx_r <= 52'(rx_r * $signed({1'b0, scale}));
      my_r <= 52'(ry_r * $signed({1'b0, scale}));
    end
    if (cmd.finish) begin
      sx_r <= sat(fx_v);
      sy_r <= sat(fy_v);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) full_r <= 1'b0;
    else if (cmd.load) full_r <= (op == OP_APPEND) && count_r[IdxW];
  end

  // Result fields depend on the last item's operation.
  op_t op_r;
  always_ff @(posedge clk) if (cmd.load) op_r <= op;

  logic q;
  assign q     = (op_r == OP_QUERY) && bfound_r;
  assign sx    = q ? sx_r : '0;
  assign sy    = q ? sy_r : '0;
  assign found = q;
  assign idx   = q ? bidx_r : '0;
  assign full  = full_r;

endmodule

// ----- rtl/polygon_support_point_search.sv -----
// Support-point search over a polygon of up to 64 vertices. Each input beat
// appends a vertex, clears the shape, queries, or (for an unknown operation)
// does nothing; exactly one result beat follows. A query runs a sine
// evaluation, a scan that reads one vertex per cycle from the table memory,
// and a transform of the chosen vertex. The next input beat is taken after
// the result beat is delivered. Configuration writes must be issued while
// the block is idle.
module polygon_support_point_search import pssp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             in_operation,
  input  logic signed [15:0]     in_vertex_x,
  input  logic signed [15:0]     in_vertex_y,
  input  logic [15:0]            in_direction_angle,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [OutW-1:0] out_support_x,
  output logic signed [OutW-1:0] out_support_y,
  output logic                   out_found,
  output logic [IdxW-1:0]        out_vertex_index,
  output logic                   out_table_full,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  logic [23:0]            cfg_data
);

  logic [15:0] rot_r, scale_r;
  logic signed [OutW-1:0] offx_r, offy_r;
  cmd_t cmd;
  stat_t stat;
  logic busy, in_beat;
  op_t op;

  assign op = op_t'(in_operation);
  assign in_ready = !busy;
  assign in_beat = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_r   <= '0;
      scale_r <= 16'd256;
      offx_r  <= '0;
      offy_r  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ROT:   rot_r   <= cfg_data[15:0];
        CFG_SCALE: scale_r <= cfg_data[15:0];
        CFG_OFFX:  offx_r  <= cfg_data;
        CFG_OFFY:  offy_r  <= cfg_data;
        default:   ;
      endcase
    end
  end

  pssp_ctrl u_ctrl (
    .clk, .rst_n, .in_beat, .op, .out_taken(out_valid && out_ready),
    .stat, .cmd, .busy, .out_valid
  );

  pssp_dp u_dp (
    .clk, .rst_n, .cmd, .stat, .op,
    .vx(in_vertex_x), .vy(in_vertex_y), .dir(in_direction_angle),
    .rot(rot_r), .scale(scale_r), .offx(offx_r), .offy(offy_r),
    .sx(out_support_x), .sy(out_support_y), .found(out_found),
    .idx(out_vertex_index), .full(out_table_full)
  );

endmodule

// ----- bench/polygon_support_point_search_tb.sv -----
module polygon_support_point_search_tb;
  import pssp_pkg::*;

  localparam int StallLimit = 5000;
  localparam int DrainCycles = 100;
  localparam int HoldCycles = 400;

  typedef struct {
    op_t              op;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic [15:0]      angle;
  } poly_cmd_t;

  typedef struct {
    logic [23:0] sx;
    logic [23:0] sy;
    logic        found;
    logic [5:0]  idx;
    logic        full;
  } support_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_operation = '0;
  logic signed [15:0] in_vertex_x = '0;
  logic signed [15:0] in_vertex_y = '0;
  logic [15:0] in_direction_angle = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [OutW-1:0] out_support_x;
  logic signed [OutW-1:0] out_support_y;
  logic out_found;
  logic [IdxW-1:0] out_vertex_index;
  logic out_table_full;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [23:0] cfg_data = '0;

  // Shadow copy of the polygon table and the transform registers.
  longint shadow_x [MaxVertices];
  longint shadow_y [MaxVertices];
  int     shadow_count = 0;
  longint shadow_sum_x = 0;
  longint shadow_sum_y = 0;
  logic [15:0] rot_angle = 16'd0;
  logic [15:0] scale_q88 = 16'd256;
  longint world_x = 0;
  longint world_y = 0;

  poly_cmd_t pending_cmds[$];
  support_t  expected_support[$];
  poly_cmd_t cur_cmd;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_request = 1'b0;
  bit hold_done = 1'b0;
  int hold_count = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  polygon_support_point_search i_dut (.*);

  always #5 clk = ~clk;

  // Q1.14 sine of a turn angle, polynomial in the first quadrant.
  function automatic longint turn_sin(logic [15:0] a);
    longint z, z2, t, r;
    z = longint'(a[13:0]) << 1;
    if (a[14]) z = 32768 - z;
    z2 = (z * z) >>> 15;
    t = (z2 * 2320) >>> 15;
    t = 21024 - t;
    t = (z2 * t) >>> 15;
    t = 51472 - t;
    r = (((z * t) >>> 15) + 1) >>> 1;
    if (r > 16384) r = 16384;
    return a[15] ? -r : r;
  endfunction

  function automatic longint turn_cos(logic [15:0] a);
    return turn_sin(a + 16'd16384);
  endfunction

  // Scale, round to whole units (Q.0), offset and saturate one rotated coordinate.
  function automatic logic [23:0] place_coord(longint r, longint off);
    longint v;
    v = r * longint'(scale_q88);
    v = ((v + (longint'(1) << 21)) >>> 22) + off;
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return v[23:0];
  endfunction

  // Apply one command to the shadow table and work out its result beat.
  function automatic support_t search_support(poly_cmd_t c);
    support_t s;
    longint dc, ds, dsum, best, d, rc, rs, px, py;
    logic [15:0] da;
    s = '{default: '0};
    case (c.op)
      OP_APPEND: begin
        if (shadow_count < MaxVertices) begin
          shadow_x[shadow_count] = c.vx;
          shadow_y[shadow_count] = c.vy;
          shadow_sum_x += c.vx;
          shadow_sum_y += c.vy;
          shadow_count++;
        end else begin
          s.full = 1'b1;
        end
      end
      OP_CLEAR: begin
        shadow_count = 0;
        shadow_sum_x = 0;
        shadow_sum_y = 0;
      end
      OP_QUERY: begin
        da = c.angle - rot_angle;
        dc = turn_cos(da);
        ds = turn_sin(da);
        dsum = dc * shadow_sum_x + ds * shadow_sum_y;
        best = 0;
        for (int i = 0; i < shadow_count; i++) begin
          d = shadow_count * (dc * shadow_x[i] + ds * shadow_y[i]) - dsum;
          if (d > best) begin
            best = d;
            s.idx = 6'(i);
            s.found = 1'b1;
          end
        end
        if (s.found) begin
          px = shadow_x[s.idx];
          py = shadow_y[s.idx];
          rc = turn_cos(rot_angle);
          rs = turn_sin(rot_angle);
          s.sx = place_coord(px * rc - py * rs, world_x);
          s.sy = place_coord(px * rs + py * rc, world_y);
        end
      end
      default: ;
    endcase
    return s;
  endfunction

  // Appends one command to the pending list.
  function automatic void add_cmd(poly_cmd_t c);
    pending_cmds.insert(pending_cmds.size(), c);
  endfunction

  // Sender: takes the next pending command once the current beat is gone.
  always @(posedge clk) begin
    bit busy;
    busy = in_valid && !in_ready;
    if (in_valid && in_ready)
      expected_support.insert(expected_support.size(), search_support(cur_cmd));
    if (rst_n && !busy) begin
      if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_cmd = pending_cmds.pop_front();
        in_valid <= 1'b1;
        in_operation <= cur_cmd.op;
        in_vertex_x <= cur_cmd.vx;
        in_vertex_y <= cur_cmd.vy;
        in_direction_angle <= cur_cmd.angle;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off to back the block up.
  always @(posedge clk) begin
    if (hold_request && !hold_done) begin
      hold_done <= 1'b1;
      hold_count <= HoldCycles;
      out_ready <= 1'b0;
    end else if (hold_count > 0) begin
      hold_count <= hold_count - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Result checker against the oldest expectation.
  always @(posedge clk) begin
    support_t e;
    if (out_valid && out_ready) begin
      if (expected_support.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: x=%h y=%h found=%b idx=%0d full=%b",
                   out_support_x, out_support_y, out_found, out_vertex_index,
                   out_table_full);
      end else begin
        e = expected_support.pop_front();
        if (out_support_x !== e.sx || out_support_y !== e.sy ||
            out_found !== e.found || out_vertex_index !== e.idx ||
            out_table_full !== e.full) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result mismatch: exp x=%h y=%h found=%b idx=%0d full=%b",
                     e.sx, e.sy, e.found, e.idx, e.full);
            $display("                 got x=%h y=%h found=%b idx=%0d full=%b",
                     out_support_x, out_support_y, out_found, out_vertex_index,
                     out_table_full);
          end
        end
      end
    end
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [23:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    case (idx)
      CFG_ROT:   rot_angle = value[15:0];
      CFG_SCALE: scale_q88 = value[15:0];
      CFG_OFFX:  world_x = longint'($signed(value));
      default:   world_y = longint'($signed(value));
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic set_transform(logic [15:0] rot, logic [15:0] scl, logic [23:0] ox,
                               logic [23:0] oy);
    write_reg(CFG_ROT, {8'd0, rot});
    write_reg(CFG_SCALE, {8'd0, scl});
    write_reg(CFG_OFFX, ox);
    write_reg(CFG_OFFY, oy);
  endtask

  function automatic poly_cmd_t make_cmd(op_t op, int x, int y, int a);
    poly_cmd_t c;
    c.op = op;
    c.vx = 16'(x);
    c.vy = 16'(y);
    c.angle = 16'(a);
    return c;
  endfunction

  function automatic int rand_coord();
    if ($urandom_range(3) == 0) return int'($signed(16'($urandom)));
    return $urandom_range(4000) - 2000;
  endfunction

  // Well-formed shapes with random content, mixed with noise beats.
  task automatic queue_shapes(int target);
    int n, k;
    n = 0;
    while (n < target) begin
      if ($urandom_range(9) == 0) begin
        add_cmd(make_cmd(op_t'($urandom_range(3)), $urandom, $urandom, $urandom));
        n++;
      end else begin
        add_cmd(make_cmd(OP_CLEAR, $urandom, $urandom, $urandom));
        k = ($urandom_range(19) == 0) ? $urandom_range(66, 60) : $urandom_range(8, 1);
        for (int i = 0; i < k; i++)
          add_cmd(make_cmd(OP_APPEND, rand_coord(), rand_coord(), $urandom));
        n += k + 1;
        k = $urandom_range(6, 2);
        for (int i = 0; i < k; i++)
          add_cmd(make_cmd(OP_QUERY, $urandom, $urandom, $urandom));
        n += k;
      end
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_cmds.size() != 0 || in_valid || expected_support.size() != 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty shape, extreme vertices, the four axes, unknown op, full table.
    add_cmd(make_cmd(OP_QUERY, 0, 0, 0));
    add_cmd(make_cmd(OP_APPEND, -32768, -32768, 16'hffff));
    add_cmd(make_cmd(OP_APPEND, 32767, 32767, 0));
    add_cmd(make_cmd(OP_APPEND, 32767, -32768, 0));
    add_cmd(make_cmd(OP_APPEND, -32768, 32767, 0));
    for (int a = 0; a < 4; a++)
      add_cmd(make_cmd(OP_QUERY, 0, 0, a * 16384));
    add_cmd(make_cmd(OP_QUERY, 0, 0, 8192));
    add_cmd(make_cmd(OP_NONE, -1, -1, 16'hffff));
    add_cmd(make_cmd(OP_CLEAR, 0, 0, 0));
    add_cmd(make_cmd(OP_QUERY, 0, 0, 0));
    // Equal vertices tie, so nothing lies above the mean.
    add_cmd(make_cmd(OP_APPEND, 100, 100, 0));
    add_cmd(make_cmd(OP_APPEND, 100, 100, 0));
    add_cmd(make_cmd(OP_QUERY, 0, 0, 0));
    add_cmd(make_cmd(OP_CLEAR, 0, 0, 0));
    for (int i = 0; i < MaxVertices + 2; i++)
      add_cmd(make_cmd(OP_APPEND, (i & 1) ? 32767 : -32768, -32768, 0));
    add_cmd(make_cmd(OP_QUERY, 0, 0, 16384));
    add_cmd(make_cmd(OP_QUERY, 0, 0, 0));
    wait_idle();

    // Random phases over the idle patterns and transform settings.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      case (ph)
        0: set_transform(16'd0, 16'd0, 24'h000000, 24'h000000);
        1: set_transform(16'hffff, 16'hffff, 24'h7fffff, 24'h800000);
        2: set_transform(16'd16384, 16'hffff, 24'h800000, 24'h7fffff);
        3: set_transform(16'd0, 16'd256, 24'h000000, 24'h000000);
        default: set_transform(16'($urandom), 16'($urandom), 24'($urandom),
                               24'($urandom));
      endcase
      queue_shapes(40);
      if (ph == 4) hold_request <= 1'b1;
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
